@@ design/dnsrw_pkg.sv @@
package dnsrw_pkg;

	localparam int MAX_QUERY_BYTES_DEF  = 512;
	localparam int EXTRA_COPY_BYTES_DEF = 11;

	localparam logic [31:0] TTL_RESET = 32'h6666_0000;

	localparam logic [1:0] RC_ANSWER   = 2'd0;
	localparam logic [1:0] RC_FORMERR  = 2'd1;
	localparam logic [1:0] RC_SERVFAIL = 2'd2;
	localparam logic [1:0] RC_NOREPLY  = 2'd3;

	localparam int HDR_FLAGS_HI = 2;
	localparam int HDR_FLAGS_LO = 3;
	localparam int HDR_COUNTS   = 4;
	localparam int HDR_AN_HI    = 6;
	localparam int HDR_AN_LO    = 7;
	localparam int HDR_LAST     = 11;

	localparam logic [7:0] FLAGS_HI_MASK = 8'hF9;
	localparam logic [7:0] FLAGS_LO_MASK = 8'h10;
	localparam logic [7:0] FLAG_QR       = 8'h80;
	localparam logic [7:0] FLAG_AA       = 8'h04;

	localparam logic [2:0] QTAIL_LEN = 3'd4;
	localparam int         REC_LEN   = 16;
	localparam int         REC_IDX_W = $clog2(REC_LEN + 1);

	typedef struct packed {
		logic [7:0]  request_byte;
		logic        request_last;
		logic [1:0]  response_code;
		logic [31:0] answer_address;
	} req_t;

	typedef struct packed {
		logic [7:0] response_byte;
		logic       response_last;
	} rsp_t;

	// one pending reply byte, optionally followed by the answer record
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        rec;
		logic        rec_last;
		logic [31:0] address;
	} step_t;

	function automatic logic [7:0] rec_byte(input logic [3:0] idx, input logic [31:0] ttl,
		input logic [31:0] addr);
		logic [7:0] b;
		b = 8'h00;
		case (idx)
			4'd0:  b = 8'hC0;
			4'd1:  b = 8'h0C;
			4'd2:  b = 8'h00;
			4'd3:  b = 8'h01;
			4'd4:  b = 8'h00;
			4'd5:  b = 8'h01;
			4'd6:  b = ttl[31:24];
			4'd7:  b = ttl[23:16];
			4'd8:  b = ttl[15:8];
			4'd9:  b = ttl[7:0];
			4'd10: b = 8'h00;
			4'd11: b = 8'h04;
			4'd12: b = addr[31:24];
			4'd13: b = addr[23:16];
			4'd14: b = addr[15:8];
			4'd15: b = addr[7:0];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ design/dnsrw_core.sv @@
module dnsrw_core #(
	parameter int MAX_QUERY_BYTES  = dnsrw_pkg::MAX_QUERY_BYTES_DEF,
	parameter int EXTRA_COPY_BYTES = dnsrw_pkg::EXTRA_COPY_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  dnsrw_pkg::req_t   req,
	output logic              s1_valid,
	output dnsrw_pkg::step_t  s1_step,
	input  logic              s1_pop
);
	import dnsrw_pkg::*;

	localparam int PosW = $clog2(MAX_QUERY_BYTES + 1);

	typedef enum logic [2:0] {
		PH_HEADER, PH_NAME, PH_QTAIL, PH_EXTRA, PH_ECHO, PH_DRAIN
	} phase_t;

	phase_t         phase_q, phase_n;
	logic [PosW-1:0] pos_q, pos_n;
	logic [1:0]     code_q, code_c;
	logic [31:0]    addr_q, addr_c;
	logic [2:0]     tail_q, tail_n, tail_inc;
	logic [3:0]     extra_q, extra_n, extra_inc;
	logic           first_c, endnow, done, emit, last, rec, rec_last;
	logic [7:0]     b, v;
	logic           accept;
	step_t          step_s1;
	logic           valid_s1;

	assign req_ready = !valid_s1 || s1_pop;
	assign accept    = req_valid && req_ready;
	assign s1_valid  = valid_s1;
	assign s1_step   = step_s1;

	always_comb begin
		b         = req.request_byte;
		first_c   = (phase_q == PH_HEADER) && (pos_q == '0);
		code_c    = first_c ? req.response_code : code_q;
		addr_c    = first_c ? req.answer_address : addr_q;
		endnow    = req.request_last || (pos_q >= PosW'(MAX_QUERY_BYTES - 1));
		tail_inc  = tail_q + 3'd1;
		extra_inc = extra_q + 4'd1;
		phase_n   = phase_q;
		tail_n    = tail_q;
		extra_n   = extra_q;
		pos_n     = pos_q;
		v         = b;
		emit      = 1'b0;
		last      = 1'b0;
		rec       = 1'b0;
		rec_last  = 1'b0;
		done      = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (code_c == RC_NOREPLY) begin
					done = 1'b1;
				end else begin
					if (pos_q == PosW'(HDR_FLAGS_HI)) begin
						v = (b & FLAGS_HI_MASK) | FLAG_QR | ((code_c == RC_ANSWER) ? FLAG_AA : 8'h00);
					end else if (pos_q == PosW'(HDR_FLAGS_LO)) begin
						v = (b & FLAGS_LO_MASK) | {6'd0, code_c};
					end else if (code_c == RC_ANSWER && pos_q == PosW'(HDR_AN_HI)) begin
						v = 8'h00;
					end else if (code_c == RC_ANSWER && pos_q == PosW'(HDR_AN_LO)) begin
						v = 8'h01;
					end else if (code_c == RC_FORMERR && pos_q >= PosW'(HDR_COUNTS)) begin
						v = 8'h00;
					end
					emit = 1'b1;
					last = endnow || (code_c == RC_FORMERR && pos_q == PosW'(HDR_LAST));
					if (last) begin
						done = 1'b1;
					end else if (pos_q == PosW'(HDR_LAST)) begin
						phase_n = (code_c == RC_ANSWER) ? PH_NAME : PH_ECHO;
					end
				end
			end
			PH_NAME: begin
				emit = 1'b1;
				last = endnow;
				if (endnow) begin
					done = 1'b1;
				end else if (b == 8'h00) begin
					phase_n = PH_QTAIL;
					tail_n  = '0;
				end
			end
			PH_QTAIL: begin
				tail_n = tail_inc;
				emit   = 1'b1;
				if (tail_inc >= QTAIL_LEN) begin
					rec      = 1'b1;
					rec_last = endnow || (EXTRA_COPY_BYTES == 0);
					if (rec_last) begin
						done = 1'b1;
					end else begin
						phase_n = PH_EXTRA;
						extra_n = '0;
					end
				end else begin
					last = endnow;
					done = endnow;
				end
			end
			PH_EXTRA: begin
				extra_n = extra_inc;
				emit    = 1'b1;
				last    = endnow || (extra_inc >= 4'(EXTRA_COPY_BYTES));
				done    = last;
			end
			PH_ECHO: begin
				emit = 1'b1;
				last = endnow;
				done = endnow;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
		if (req.request_last) begin
			pos_n   = '0;
			phase_n = PH_HEADER;
			tail_n  = '0;
			extra_n = '0;
		end else begin
			if (done) begin
				phase_n = PH_DRAIN;
			end
			if (pos_q < PosW'(MAX_QUERY_BYTES)) begin
				pos_n = pos_q + PosW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			pos_q    <= '0;
			code_q   <= '0;
			addr_q   <= '0;
			tail_q   <= '0;
			extra_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_n;
				pos_q   <= pos_n;
				code_q  <= code_c;
				addr_q  <= addr_c;
				tail_q  <= tail_n;
				extra_q <= extra_n;
			end
			if (accept && emit) begin
				valid_s1 <= 1'b1;
			end else if (s1_pop) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			step_s1.data     <= v;
			step_s1.last     <= last;
			step_s1.rec      <= rec;
			step_s1.rec_last <= rec_last;
			step_s1.address  <= addr_c;
		end
	end

endmodule

@@ design/dnsrw_emit.sv @@
module dnsrw_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s1_valid,
	input  dnsrw_pkg::step_t  s1_step,
	output logic              s1_pop,
	input  logic [31:0]       ttl,
	output logic              rsp_valid,
	output dnsrw_pkg::rsp_t   rsp,
	input  logic              rsp_ready
);
	import dnsrw_pkg::*;

	logic [REC_IDX_W-1:0] idx_q;
	logic                 load, final_c;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q, rsp_c;

	assign load    = !rsp_valid_q || rsp_ready;
	assign final_c = (!s1_step.rec && idx_q == '0) || (idx_q == REC_IDX_W'(REC_LEN));
	assign s1_pop  = s1_valid && load && final_c;

	always_comb begin
		if (idx_q == '0) begin
			rsp_c.response_byte = s1_step.data;
			rsp_c.response_last = s1_step.last;
		end else begin
			rsp_c.response_byte = rec_byte(4'(idx_q - REC_IDX_W'(1)), ttl, s1_step.address);
			rsp_c.response_last = (idx_q == REC_IDX_W'(REC_LEN)) && s1_step.rec_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= s1_valid;
			if (s1_valid) begin
				idx_q <= final_c ? '0 : idx_q + REC_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && s1_valid) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ design/dns_response_rewriter_top.sv @@
// channel  | handshake             | payload
// req      | req_valid/req_ready   | req (dnsrw_pkg::req_t), one query byte
// rsp      | rsp_valid/rsp_ready   | rsp (dnsrw_pkg::rsp_t), one reply byte
// cfg      | cfg_we                | cfg_wdata, answer TTL
//
// One query byte per cycle while req_ready is high; reply bytes leave via the output register.
// In an answer reply, the byte that completes the question adds the 16-byte answer
// record: the record serializer holds req_ready low while it drains.
// Reset is asynchronous; it clears control state and loads the TTL default.
// A stall on rsp backs up through the output register and the step register.
module dns_response_rewriter_top #(
	parameter int MAX_QUERY_BYTES  = dnsrw_pkg::MAX_QUERY_BYTES_DEF,
	parameter int EXTRA_COPY_BYTES = dnsrw_pkg::EXTRA_COPY_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  dnsrw_pkg::req_t  req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output dnsrw_pkg::rsp_t  rsp,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata
);
	import dnsrw_pkg::*;

	logic [31:0] ttl_q;
	logic        s1_valid, s1_pop;
	step_t       s1_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (cfg_we) begin
			ttl_q <= cfg_wdata;
		end
	end

	dnsrw_core #(
		.MAX_QUERY_BYTES  (MAX_QUERY_BYTES),
		.EXTRA_COPY_BYTES (EXTRA_COPY_BYTES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.s1_valid  (s1_valid),
		.s1_step   (s1_step),
		.s1_pop    (s1_pop)
	);

	dnsrw_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1_step   (s1_step),
		.s1_pop    (s1_pop),
		.ttl       (ttl_q),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_ready (rsp_ready)
	);

	a_stall_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && !s1_pop) |-> !req_ready)
		else $error("input accepted while step register busy");

	a_pop_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		s1_pop |-> (s1_valid && (!rsp_valid || rsp_ready)))
		else $error("step released without output load");

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		s1_pop |=> rsp_valid)
		else $error("released step produced no output");

endmodule
